### rtl/dirc_pkg.sv
package dirc_pkg;

   // Table size and the widths that follow from it.
   localparam int RULE_DEPTH = 16;
   localparam int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CNT_RAW_W  = $clog2(RULE_DEPTH + 1);
   localparam int SCAN_W     = (CNT_RAW_W > 5) ? CNT_RAW_W : 5;
   localparam int COUNT_W    = 5;
   localparam int HIT_IDX_W  = 4;

   localparam logic [15:0] MIN_HEADER_LEN = 16'd20;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Result queue at the output of the back part.
   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR_W = 1;
   localparam int OUT_CNT_W = 2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   localparam logic DIR_IN  = 1'b0;
   localparam logic DIR_OUT = 1'b1;

   localparam logic [1:0] ACT_ALLOW  = 2'd0;
   localparam logic [1:0] ACT_DENY   = 2'd1;
   localparam logic [1:0] ACT_ROUTE  = 2'd2;
   localparam logic [1:0] ACT_IGNORE = 2'd3;

   localparam logic [1:0] VERDICT_ALLOW  = 2'd0;
   localparam logic [1:0] VERDICT_DENY   = 2'd1;
   localparam logic [1:0] VERDICT_ROUTE  = 2'd2;
   localparam logic [1:0] VERDICT_REJECT = 2'd3;

   // Operation codes chosen by the front part.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_PASS  = 2'd1;
   localparam logic [1:0] OP_SHORT = 2'd2;
   localparam logic [1:0] OP_SCAN  = 2'd3;

   typedef struct packed {
      logic        command;
      logic        direction;
      logic [15:0] packet_length;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] source_mask;
      logic [31:0] dest_mask;
      logic [3:0]  rule_index;
      logic [1:0]  rule_action;
      logic [31:0] target_addr;
      logic [15:0] gateway_port;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic        hit;
      logic [3:0]  hit_index;
      logic [31:0] route_addr;
      logic [15:0] route_port;
   } rsp_type;

   typedef struct packed {
      logic        direction;
      logic [31:0] src_value;
      logic [31:0] source_mask;
      logic [31:0] dst_value;
      logic [31:0] dest_mask;
      logic [1:0]  action;
      logic [31:0] target_addr;
      logic [15:0] gateway_port;
   } rule_type;

   typedef struct packed {
      logic [1:0] op;
      req_type    item;
   } work_type;

   // Head of the queue as seen by the back part.
   typedef struct packed {
      logic     valid;
      work_type work;
   } head_type;

endpackage

### rtl/dirc_ram.sv
module dirc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/dirc_front.sv
module dirc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  dirc_pkg::req_type               req_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dirc_pkg::COUNT_W-1:0]    csr_data,
   output dirc_pkg::head_type              head,
   input  logic                            head_pop,
   output logic [dirc_pkg::COUNT_W-1:0]    rule_count
);

   import dirc_pkg::*;

   work_type               q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic [COUNT_W-1:0]     rule_count_ff;
   logic [COUNT_W-1:0]     rule_count_in;
   logic                   accept;
   logic                   enq;
   logic                   deq;
   logic                   index_ok;
   logic [SCAN_W-1:0]      index_wide;
   work_type               new_work;

   assign req_full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   // A write to a slot beyond the table is accepted and dropped.
   assign index_wide = SCAN_W'(req_item.rule_index);
   assign index_ok   = (index_wide < SCAN_W'(RULE_DEPTH));

   always_comb begin
      new_work.item = req_item;
      if (req_item.command == CMD_WRITE) begin
         new_work.op = OP_WRITE;
      end else if (rule_count_ff == '0) begin
         new_work.op = OP_PASS;
      end else if (req_item.packet_length < MIN_HEADER_LEN) begin
         new_work.op = OP_SHORT;
      end else begin
         new_work.op = OP_SCAN;
      end
   end

   assign enq = accept && ((req_item.command != CMD_WRITE) || index_ok);
   assign deq = head_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in     = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in     = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in      = count_ff + QUEUE_CNT_W'(enq) - QUEUE_CNT_W'(deq);
      rule_count_in = (csr_valid && csr_ready) ? csr_data : rule_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         rule_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         rule_count_ff <= rule_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_mem_ff[wr_ptr_ff] <= new_work;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.work  = q_mem_ff[rd_ptr_ff];
   assign rule_count = rule_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("work queue count beyond its depth");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (deq && !enq) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("work queue count did not drop on a pop");
`endif

endmodule

### rtl/dirc_back.sv
module dirc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  dirc_pkg::head_type           head,
   output logic                         head_pop,
   input  logic [dirc_pkg::COUNT_W-1:0] rule_count,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output dirc_pkg::rsp_type            rsp_item
);

   import dirc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic              state_ff;
   logic              state_in;
   logic [SCAN_W-1:0] issue_ff;
   logic [SCAN_W-1:0] issue_in;
   logic              cmp_valid_ff;
   logic              cmp_valid_in;
   logic [SCAN_W-1:0] cmp_idx_ff;
   logic [SCAN_W-1:0] cmp_idx_in;
   logic [SCAN_W-1:0] scan_len;
   logic [SCAN_W-1:0] count_wide;
   logic [SCAN_W-1:0] waddr_wide;

   logic                 ram_we;
   logic                 ram_re;
   logic [IDX_W-1:0]     ram_raddr;
   logic [IDX_W-1:0]     ram_waddr;
   rule_type             ram_wdata;
   logic [$bits(rule_type)-1:0] ram_rdata;
   rule_type             rule;

   logic    match;
   logic    out_push;
   logic    out_pop;
   logic    out_space;
   rsp_type res;
   rsp_type out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff;
   logic [OUT_PTR_W-1:0] out_rd_ff;
   logic [OUT_CNT_W-1:0] out_count_ff;

   req_type item;
   assign item = head.work.item;

   // Scan length is the rule count clipped to the table size.
   assign count_wide = SCAN_W'(rule_count);
   assign scan_len   = (count_wide > SCAN_W'(RULE_DEPTH)) ? SCAN_W'(RULE_DEPTH) : count_wide;

   assign waddr_wide = SCAN_W'(item.rule_index);
   assign ram_waddr  = waddr_wide[IDX_W-1:0];

   always_comb begin
      ram_wdata.direction    = item.direction;
      ram_wdata.src_value    = item.src_addr;
      ram_wdata.source_mask  = item.source_mask;
      ram_wdata.dst_value    = item.dst_addr;
      ram_wdata.dest_mask    = item.dest_mask;
      ram_wdata.action       = item.rule_action;
      ram_wdata.target_addr  = item.target_addr;
      ram_wdata.gateway_port = item.gateway_port;
   end

   dirc_ram #(
      .WIDTH ($bits(rule_type)),
      .DEPTH (RULE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rule = rule_type'(ram_rdata);

   assign match = (rule.direction == item.direction)
      && ((rule.src_value == '0) || ((item.src_addr & rule.source_mask) == rule.src_value))
      && ((rule.dst_value == '0) || ((item.dst_addr & rule.dest_mask) == rule.dst_value))
      && (rule.action != ACT_IGNORE);

   assign out_space = (out_count_ff != OUT_CNT_W'(OUT_DEPTH));

   always_comb begin
      head_pop     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = issue_ff[IDX_W-1:0];
      out_push     = 1'b0;
      res          = '0;
      state_in     = state_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               case (head.work.op)
                  OP_WRITE: begin
                     ram_we   = 1'b1;
                     head_pop = 1'b1;
                  end
                  OP_PASS: begin
                     if (out_space) begin
                        res.verdict = VERDICT_ALLOW;
                        out_push    = 1'b1;
                        head_pop    = 1'b1;
                     end
                  end
                  OP_SHORT: begin
                     if (out_space) begin
                        res.verdict = VERDICT_REJECT;
                        out_push    = 1'b1;
                        head_pop    = 1'b1;
                     end
                  end
                  OP_SCAN: begin
                     if (out_space) begin
                        ram_re       = 1'b1;
                        ram_raddr    = '0;
                        issue_in     = SCAN_W'(1);
                        cmp_valid_in = 1'b1;
                        cmp_idx_in   = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cmp_valid_ff && match) begin
               res.hit       = 1'b1;
               res.hit_index = cmp_idx_ff[HIT_IDX_W-1:0];
               case (rule.action)
                  ACT_DENY: res.verdict = VERDICT_DENY;
                  ACT_ROUTE: begin
                     if (item.direction == DIR_OUT) begin
                        res.verdict    = VERDICT_ROUTE;
                        res.route_addr = rule.target_addr;
                        res.route_port = rule.gateway_port;
                     end else begin
                        res.verdict = VERDICT_REJECT;
                     end
                  end
                  default: res.verdict = VERDICT_ALLOW;
               endcase
               out_push = 1'b1;
               head_pop = 1'b1;
               state_in = ST_IDLE;
            end else if (cmp_valid_ff && (cmp_idx_ff == scan_len - 1'b1)) begin
               res.verdict = VERDICT_ALLOW;
               out_push    = 1'b1;
               head_pop    = 1'b1;
               state_in    = ST_IDLE;
            end else if (issue_ff < scan_len) begin
               ram_re       = 1'b1;
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_pop = rsp_pop && (out_count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_idx_ff   <= '0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         cmp_idx_ff   <= cmp_idx_in;
         out_wr_ff    <= out_push ? out_wr_ff + 1'b1 : out_wr_ff;
         out_rd_ff    <= out_pop ? out_rd_ff + 1'b1 : out_rd_ff;
         out_count_ff <= out_count_ff + OUT_CNT_W'(out_push) - OUT_CNT_W'(out_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= res;
      end
   end

   assign rsp_empty = (out_count_ff == '0);
   assign rsp_item  = out_mem_ff[out_rd_ff];

`ifndef SYNTHESIS
   a_scan_has_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> head.valid)
      else $error("scan running without a queued item");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE) && !ram_re)
      else $error("rule write during a scan");
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_space || out_pop))
      else $error("result pushed into a full output queue");
`endif

endmodule

### rtl/directional_ip_rule_classifier.sv
// First-match IPv4 rule classifier with a rule table of RULE_DEPTH entries.
// Input channel (req_push / req_full / req_item): an item is taken on a clock
// edge with req_push high and req_full low. A write item stores one rule at
// rule_index and gives no result; a check item gives exactly one result.
// Result channel (rsp_empty / rsp_pop / rsp_item): the oldest result is shown
// while rsp_empty is low and leaves on an edge with rsp_pop high.
// Control port (csr_valid / csr_ready / csr_data): writes the rule count; it
// is always ready. The user must write it only while the block is idle; the
// block does not enforce this. A check on an empty table or on a packet
// shorter than 20 bytes takes its verdict straight from the work queue head,
// with no table read. A table check reads one rule per cycle from the rule
// memory and stops at the first matching rule or after the last of the
// min(rule_count, RULE_DEPTH) active rules. Writes go at one per cycle while
// the back part is idle, and short-cut checks also need result queue room; a
// table check holds the back part until its scan ends.
// A two-entry work queue and a two-entry result queue decouple the sides; a
// stalled receiver backs up the results, then the work queue, then req_full.
// Reset empties both queues, stops any scan and clears the rule count; the
// rule memory is not cleared and a slot reads as garbage until written.
module directional_ip_rule_classifier (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  dirc_pkg::req_type            req_item,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output dirc_pkg::rsp_type            rsp_item,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dirc_pkg::COUNT_W-1:0] csr_data
);

   import dirc_pkg::*;

   // Work queue head handed from the front to the back part.
   head_type           head;
   logic               head_pop;
   logic [COUNT_W-1:0] rule_count;

   // The front part takes items, sorts them into table writes, trivial
   // verdicts and table scans, and holds them in the work queue.
   dirc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .head       (head),
      .head_pop   (head_pop),
      .rule_count (rule_count)
   );

   // The back part owns the rule memory, runs the scans and buffers results.
   // Writes are done in queue order, so a check always sees the table as it
   // stood when the check was taken.
   dirc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_pop   (head_pop),
      .rule_count (rule_count),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

### dv/rule_classifier_checker.sv
`timescale 1ns / 1ps

module rule_classifier_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic                         req_full,
   input  dirc_pkg::req_type            req_item,
   input  logic                         rsp_empty,
   input  logic                         rsp_pop,
   input  dirc_pkg::rsp_type            rsp_item,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [dirc_pkg::COUNT_W-1:0] csr_data,
   output int                           fail_count,
   output int                           pending
);
   import dirc_pkg::*;

   rule_type           rule_table [RULE_DEPTH];
   logic [COUNT_W-1:0] active_rules;
   rsp_type            verdict_queue [$];

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] classifier mismatch: %s", $time, msg);
   endtask

   // First-match scan over the active part of the rule table.
   function automatic rsp_type classify_packet(input req_type pkt);
      rsp_type     res;
      rule_type    r;
      int unsigned scan_len;
      logic        found;
      logic [3:0]  slot_idx;
      res   = '0;
      found = 1'b0;
      if (active_rules == 0) begin
         return res;
      end
      if (pkt.packet_length < MIN_HEADER_LEN) begin
         res.verdict = VERDICT_REJECT;
         return res;
      end
      scan_len = (int'(active_rules) > RULE_DEPTH) ? RULE_DEPTH : int'(active_rules);
      for (int unsigned i = 0; i < scan_len; i++) begin
         r = rule_table[i];
         if (!found && r.direction == pkt.direction
             && (r.src_value == 0 || (pkt.src_addr & r.source_mask) == r.src_value)
             && (r.dst_value == 0 || (pkt.dst_addr & r.dest_mask) == r.dst_value)
             && r.action != ACT_IGNORE) begin
            found         = 1'b1;
            slot_idx      = i[3:0];
            res.hit       = 1'b1;
            res.hit_index = slot_idx;
            if (r.action == ACT_ROUTE) begin
               if (pkt.direction == DIR_IN) begin
                  res.verdict = VERDICT_REJECT;
               end else begin
                  res.verdict    = VERDICT_ROUTE;
                  res.route_addr = r.target_addr;
                  res.route_port = r.gateway_port;
               end
            end else begin
               res.verdict = (r.action == ACT_DENY) ? VERDICT_DENY : VERDICT_ALLOW;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count   = 0;
         active_rules = '0;
         verdict_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            active_rules = csr_data;
         end
         if (rsp_pop && !rsp_empty) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected result, verdict %0d hit %0b index %0d",
                                         rsp_item.verdict, rsp_item.hit, rsp_item.hit_index));
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_item.verdict !== want.verdict)
                  report_mismatch($sformatf("verdict %0d, wanted %0d",
                                            rsp_item.verdict, want.verdict));
               if (rsp_item.hit !== want.hit)
                  report_mismatch($sformatf("hit %0b, wanted %0b", rsp_item.hit, want.hit));
               if (rsp_item.hit_index !== want.hit_index)
                  report_mismatch($sformatf("hit_index %0d, wanted %0d",
                                            rsp_item.hit_index, want.hit_index));
               if (rsp_item.route_addr !== want.route_addr)
                  report_mismatch($sformatf("route_addr %h, wanted %h",
                                            rsp_item.route_addr, want.route_addr));
               if (rsp_item.route_port !== want.route_port)
                  report_mismatch($sformatf("route_port %h, wanted %h",
                                            rsp_item.route_port, want.route_port));
            end
         end
         if (req_push && !req_full) begin
            if (req_item.command == CMD_WRITE) begin
               if (req_item.rule_index < RULE_DEPTH) begin
                  rule_table[req_item.rule_index].direction    = req_item.direction;
                  rule_table[req_item.rule_index].src_value    = req_item.src_addr;
                  rule_table[req_item.rule_index].source_mask  = req_item.source_mask;
                  rule_table[req_item.rule_index].dst_value    = req_item.dst_addr;
                  rule_table[req_item.rule_index].dest_mask    = req_item.dest_mask;
                  rule_table[req_item.rule_index].action       = req_item.rule_action;
                  rule_table[req_item.rule_index].target_addr  = req_item.target_addr;
                  rule_table[req_item.rule_index].gateway_port = req_item.gateway_port;
               end
            end else begin
               verdict_queue.push_back(classify_packet(req_item));
            end
         end
      end
      pending = verdict_queue.size();
   end

endmodule

### dv/tb_directional_ip_rule_classifier.sv
`timescale 1ns / 1ps

module tb_directional_ip_rule_classifier;
   import dirc_pkg::*;

   // The run is far shorter than this; the limit only catches a hung block.
   localparam int CYCLE_LIMIT  = 400000;
   // This many quiet cycles after the last result mean that a trailing write
   // item has surely been absorbed.
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 138;
   localparam int IDLE_PERCENT = 35;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_push  = 1'b0;
   logic               req_full;
   req_type            req_item  = '0;
   logic               rsp_empty;
   logic               rsp_pop   = 1'b0;
   rsp_type            rsp_item;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data  = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;

   // While steady is set neither side inserts idle cycles.
   logic steady = 1'b0;

   // The stimulus keeps its own picture of the table so that it can aim
   // packets at rules that will actually match.
   rule_type rule_shadow [RULE_DEPTH];
   int       aim_span = RULE_DEPTH;

   always #10 clock = ~clock;

   directional_ip_rule_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   rule_classifier_checker verdict_check (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_item   (req_item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // The result side stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_directional_ip_rule_classifier NOT OK");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the rising
   // edge that took the item. The push stays high so that a following item
   // can go out back to back.
   task automatic push_item(input req_type item);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= item;
      // The full flag only moves at a rising edge, so its value now decides
      // whether the coming edge takes the item.
      while (req_full) @(negedge clock);
      @(negedge clock);
   endtask

   // A write item. The packet length field means nothing here, so it gets
   // random content to make sure the block really ignores it.
   task automatic store_rule(input int unsigned slot, input rule_type r);
      req_type w;
      w.command       = CMD_WRITE;
      w.direction     = r.direction;
      w.packet_length = 16'($urandom_range(65535));
      w.src_addr      = r.src_value;
      w.dst_addr      = r.dst_value;
      w.source_mask   = r.source_mask;
      w.dest_mask     = r.dest_mask;
      w.rule_index    = slot[IDX_W-1:0];
      w.rule_action   = r.action;
      w.target_addr   = r.target_addr;
      w.gateway_port  = r.gateway_port;
      rule_shadow[slot[IDX_W-1:0]] = r;
      push_item(w);
   endtask

   // A check item; the fields that only a write uses carry random noise.
   task automatic check_packet(input logic dir, input logic [15:0] len,
                               input logic [31:0] src, input logic [31:0] dst);
      req_type c;
      c.command       = CMD_CHECK;
      c.direction     = dir;
      c.packet_length = len;
      c.src_addr      = src;
      c.dst_addr      = dst;
      c.source_mask   = $urandom;
      c.dest_mask     = $urandom;
      c.rule_index    = 4'($urandom_range(RULE_DEPTH - 1));
      c.rule_action   = 2'($urandom_range(3));
      c.target_addr   = $urandom;
      c.gateway_port  = 16'($urandom_range(65535));
      push_item(c);
   endtask

   // Stop sending, let every outstanding result come back and then give the
   // block enough cycles to finish any write item still in flight.
   task automatic settle();
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // The rule count is only changed with the block idle.
   task automatic set_rule_count(input logic [COUNT_W-1:0] n);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= n;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      aim_span = (n == 0 || int'(n) > RULE_DEPTH) ? RULE_DEPTH : int'(n);
   endtask

   function automatic rule_type make_rule(input logic dir,
                                          input logic [31:0] sv, input logic [31:0] sm,
                                          input logic [31:0] dv, input logic [31:0] dm,
                                          input logic [1:0] act,
                                          input logic [31:0] ta, input logic [15:0] tp);
      rule_type r;
      r.direction    = dir;
      r.src_value    = sv;
      r.source_mask  = sm;
      r.dst_value    = dv;
      r.dest_mask    = dm;
      r.action       = act;
      r.target_addr  = ta;
      r.gateway_port = tp;
      return r;
   endfunction

   function automatic logic [31:0] prefix_mask(input int unsigned bits);
      return ~(32'hFFFF_FFFF >> bits);
   endfunction

   // Random rules mostly use prefix masks with values inside the mask, the
   // way real address rules look. Some values are zero, which turns the
   // compare off, and a few lie outside their mask and can never match.
   function automatic rule_type random_rule();
      rule_type    r;
      int unsigned roll;
      r.direction   = 1'($urandom_range(1));
      r.source_mask = ($urandom_range(4) == 0) ? $urandom : prefix_mask($urandom_range(32));
      r.dest_mask   = ($urandom_range(4) == 0) ? $urandom : prefix_mask($urandom_range(32));
      roll = $urandom_range(9);
      r.src_value = (roll < 3) ? 32'h0 : (roll == 3) ? $urandom : ($urandom & r.source_mask);
      roll = $urandom_range(9);
      r.dst_value = (roll < 3) ? 32'h0 : (roll == 3) ? $urandom : ($urandom & r.dest_mask);
      r.action       = 2'($urandom_range(3));
      r.target_addr  = $urandom;
      r.gateway_port = 16'($urandom_range(65535));
      return r;
   endfunction

   // Most packets are built to hit one of the active rules, with random bits
   // in the positions the rule does not care about; the rest are random.
   // Lengths are mostly legal, with short packets and the edges mixed in.
   task automatic random_check();
      rule_type    aim;
      logic        dir;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] len;
      int unsigned roll;
      aim = rule_shadow[$urandom_range(aim_span - 1)];
      if ($urandom_range(99) < 65) begin
         dir = aim.direction;
         src = aim.src_value | ($urandom & ~aim.source_mask);
         dst = aim.dst_value | ($urandom & ~aim.dest_mask);
      end else begin
         dir = 1'($urandom_range(1));
         src = $urandom;
         dst = $urandom;
      end
      roll = $urandom_range(99);
      if (roll < 8) begin
         len = 16'($urandom_range(19));
      end else if (roll < 12) begin
         len = roll[0] ? MIN_HEADER_LEN : 16'hFFFF;
      end else begin
         len = 16'($urandom_range(20, 65535));
      end
      check_packet(dir, len, src, dst);
   endtask

   initial begin
      logic [COUNT_W-1:0] count_setting;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // An empty table allows everything, a short packet included.
      check_packet(DIR_IN, 16'd0, $urandom, $urandom);
      check_packet(DIR_OUT, 16'hFFFF, $urandom, $urandom);

      // Fill the whole table before any scan can reach it. Slot 0 is an
      // ignored rule in front of an outbound route in slot 1, slot 2 routes
      // inbound traffic (a reject), slot 3 checks only the destination and
      // slot 4 both addresses. Slots 5 to 14 can never match and slot 15
      // catches all remaining outbound traffic.
      store_rule(0, make_rule(DIR_OUT, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 32'h0,
                              ACT_IGNORE, $urandom, 16'($urandom_range(65535))));
      store_rule(1, make_rule(DIR_OUT, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 32'h0,
                              ACT_ROUTE, 32'hC0A8_0001, 16'd8080));
      store_rule(2, make_rule(DIR_IN, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0, 32'h0,
                              ACT_ROUTE, $urandom, 16'($urandom_range(65535))));
      store_rule(3, make_rule(DIR_IN, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              ACT_DENY, $urandom, 16'($urandom_range(65535))));
      store_rule(4, make_rule(DIR_IN, 32'hAC10_0000, 32'hFFF0_0000,
                              32'h0102_0304, 32'hFFFF_FFFF,
                              ACT_ALLOW, $urandom, 16'($urandom_range(65535))));
      for (int unsigned s = 5; s < RULE_DEPTH - 1; s++) begin
         store_rule(s, make_rule(DIR_IN, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                                 ACT_DENY, $urandom, 16'($urandom_range(65535))));
      end
      store_rule(RULE_DEPTH - 1, make_rule(DIR_OUT, 32'h0, 32'h0, 32'h0, 32'h0,
                                           ACT_DENY, $urandom, 16'($urandom_range(65535))));

      // A count above the table size still scans only the table.
      set_rule_count(5'd31);
      check_packet(DIR_OUT, MIN_HEADER_LEN, 32'h0A01_0203, $urandom);
      check_packet(DIR_IN, 16'hFFFF, 32'hC0A8_0101, 32'h0);
      check_packet(DIR_IN, 16'd1500, 32'h1234_5678, 32'hFFFF_FFFF);
      check_packet(DIR_IN, 16'd64, 32'hAC1F_FFFF, 32'h0102_0304);
      check_packet(DIR_IN, 16'd40, 32'h0, 32'h0);
      check_packet(DIR_OUT, 16'd40, 32'h0B00_0000, $urandom);
      check_packet(DIR_OUT, 16'd19, 32'h0A00_0001, 32'h0);

      // With one rule only the ignored entry is seen, so nothing hits.
      set_rule_count(5'd1);
      check_packet(DIR_OUT, 16'd100, 32'h0A00_0001, 32'h0);

      // Random phases, each under its own rule count. The third phase runs
      // with no idle cycles on either side.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: count_setting = 5'd16;
            1: count_setting = 5'd1;
            2: count_setting = 5'd31;
            3: count_setting = 5'd0;
            4: count_setting = 5'd8;
            5: count_setting = 5'd17;
            default: count_setting = COUNT_W'($urandom_range(2, 30));
         endcase
         set_rule_count(count_setting);
         steady <= (p == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 20) begin
               store_rule($urandom_range(RULE_DEPTH - 1), random_rule());
            end else begin
               random_check();
            end
         end
      end

      steady <= 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("tb_directional_ip_rule_classifier OK");
      end else begin
         $display("tb_directional_ip_rule_classifier NOT OK");
      end
      $finish;
   end

endmodule
